// ===== src/osd_text_overlay_defines.svh =====
// Assertion macros shared by the checker of the text overlay.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef OSD_TEXT_OVERLAY_DEFINES_SVH
`define OSD_TEXT_OVERLAY_DEFINES_SVH

// Consequent checked at the same clock edge as the antecedent.
`define OSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked at the clock edge after the antecedent has matched.
`define OSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/osd_pkg.sv =====
// Shared constants, types, font table and the font lookup function of the text overlay.
// No dependencies; every other file of the overlay but the macros header refers to it by scoped names.
`timescale 1ns / 1ps

package osd_pkg;

   localparam int MAX_CHARS   = 16;
   localparam int MAX_COORD   = 4096;
   localparam int NUM_LINES   = 2;

   localparam int COORD_W     = 12;
   localparam int LUMA_W      = 8;
   localparam int SCALE_W     = 4;
   localparam int CODE_W      = 4;
   localparam int TEXT_W      = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   // Character x positions reach origin + 15 * 6 * 15, which needs 13 bits.
   localparam int CX_W        = 13;
   // Signed distance of a pixel from a character cell or a line top.
   localparam int DIFF_W      = 14;
   // Multiples 1..8 of the scale, at most 120.
   localparam int NUM_MULT    = 8;
   localparam int MULT_W      = 7;
   // Font dot index within a cell, 0..6.
   localparam int DIGIT_W     = 3;
   localparam int GLYPH_PITCH = 6;

   localparam int FONT_W      = 5;
   localparam int FONT_H      = 7;
   localparam int FONT_GLYPHS = 14;

   localparam logic [LUMA_W-1:0] LUMA_DOT = 8'd235;
   localparam logic [LUMA_W-1:0] LUMA_BOX = 8'd16;

   localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd14;
   localparam logic [CODE_W-1:0] CODE_END     = 4'd15;

   localparam logic [COORD_W-1:0] ORIGIN_X_RESET     = 12'd24;
   localparam logic [COORD_W-1:0] ORIGIN_Y_RESET     = 12'd24;
   localparam logic [SCALE_W-1:0] GLYPH_SCALE_RESET  = 4'd3;
   localparam logic [COORD_W-1:0] LINE_SPACING_RESET = 12'd30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X     = 3'd0,
      CSR_ORIGIN_Y     = 3'd1,
      CSR_GLYPH_SCALE  = 3'd2,
      CSR_LINE_SPACING = 3'd3,
      CSR_TEXT_FIRST   = 3'd4,
      CSR_TEXT_SECOND  = 3'd5
   } csr_idx_type;

   // Rows of the 5x7 font, bit 4 is the leftmost dot. The last glyph is the space.
   localparam logic [FONT_W-1:0] FONT [FONT_GLYPHS][FONT_H] = '{
      '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
      '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
      '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
      '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
      '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
      '{5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h03},
      '{5'h06, 5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08},
      '{5'h00, 5'h1F, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00},
      '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
   };

   function automatic logic [FONT_W-1:0] font_row(input logic [CODE_W-1:0] code,
                                                   input logic [DIGIT_W-1:0] row);
      logic [FONT_W-1:0] bits;
      bits = '0;
      if (code < FONT_GLYPHS && row < FONT_H) begin
         bits = FONT[code][row];
      end
      return bits;
   endfunction

   // Geometry derived from the configuration registers.
   typedef struct packed {
      logic [MAX_CHARS-1:0][CX_W-1:0]                 cx;
      logic [NUM_LINES-1:0][CX_W-1:0]                 top;
      logic [NUM_MULT-1:0][MULT_W-1:0]                mult;
      logic [SCALE_W-1:0]                             scale;
      logic [NUM_LINES-1:0][MAX_CHARS-1:0][CODE_W-1:0] code;
      logic [NUM_LINES-1:0][MAX_CHARS-1:0]            drawn;
   } geom_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [LUMA_W-1:0]  luma;
   } pix_type;

   typedef struct packed {
      logic [MAX_CHARS-1:0][DIFF_W-1:0] dx;
      logic [NUM_LINES-1:0][DIFF_W-1:0] dy;
      logic                             in_frame;
      logic [LUMA_W-1:0]                luma;
   } diff_type;

   typedef struct packed {
      logic [MAX_CHARS-1:0]              col_box;
      logic [MAX_CHARS-1:0]              col_glyph;
      logic [MAX_CHARS-1:0][DIGIT_W-1:0] dc;
      logic [NUM_LINES-1:0]              row_box;
      logic [NUM_LINES-1:0]              row_glyph;
      logic [NUM_LINES-1:0][DIGIT_W-1:0] dr;
      logic                              in_frame;
      logic [LUMA_W-1:0]                 luma;
   } digit_type;

   typedef struct packed {
      logic [NUM_LINES-1:0][MAX_CHARS-1:0] box;
      logic [NUM_LINES-1:0][MAX_CHARS-1:0] dot;
      logic                                in_frame;
      logic [LUMA_W-1:0]                   luma;
   } cover_type;

endpackage

// ===== src/osd_ifs.sv =====
// Channel interfaces of the text overlay: pixel words in, luma words out, register writes.
// Depends on osd_pkg for the field widths.
`timescale 1ns / 1ps

interface osd_req_if;
   logic                        valid;
   logic                        ready;
   logic [osd_pkg::COORD_W-1:0] pixel_col;
   logic [osd_pkg::COORD_W-1:0] pixel_row;
   logic [osd_pkg::LUMA_W-1:0]  luma_in;

   modport source (output valid, pixel_col, pixel_row, luma_in, input ready);
   modport sink   (input valid, pixel_col, pixel_row, luma_in, output ready);
endinterface

interface osd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [osd_pkg::LUMA_W-1:0] luma_out;

   modport source (output valid, luma_out, input ready);
   modport sink   (input valid, luma_out, output ready);
endinterface

interface osd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [osd_pkg::CSR_IDX_W-1:0]  index;
   logic [osd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/osd_cfg.sv =====
// Configuration registers of the text overlay and the registered geometry derived from them.
// Depends on osd_pkg.
`timescale 1ns / 1ps

module osd_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [osd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [osd_pkg::CSR_DATA_W-1:0] csr_data,
   output osd_pkg::geom_type              geom
);

   localparam int CW = osd_pkg::CX_W;
   localparam int MW = osd_pkg::MULT_W;

   logic [osd_pkg::COORD_W-1:0] origin_x_ff;
   logic [osd_pkg::COORD_W-1:0] origin_y_ff;
   logic [osd_pkg::SCALE_W-1:0] glyph_scale_ff;
   logic [osd_pkg::COORD_W-1:0] line_spacing_ff;
   logic [osd_pkg::TEXT_W-1:0]  text_first_ff;
   logic [osd_pkg::TEXT_W-1:0]  text_second_ff;

   osd_pkg::geom_type geom_ff;
   osd_pkg::geom_type geom_in;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= osd_pkg::ORIGIN_X_RESET;
         origin_y_ff     <= osd_pkg::ORIGIN_Y_RESET;
         glyph_scale_ff  <= osd_pkg::GLYPH_SCALE_RESET;
         line_spacing_ff <= osd_pkg::LINE_SPACING_RESET;
         text_first_ff   <= '1;
         text_second_ff  <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            osd_pkg::CSR_ORIGIN_X:     origin_x_ff     <= csr_data[osd_pkg::COORD_W-1:0];
            osd_pkg::CSR_ORIGIN_Y:     origin_y_ff     <= csr_data[osd_pkg::COORD_W-1:0];
            osd_pkg::CSR_GLYPH_SCALE:  glyph_scale_ff  <= csr_data[osd_pkg::SCALE_W-1:0];
            osd_pkg::CSR_LINE_SPACING: line_spacing_ff <= csr_data[osd_pkg::COORD_W-1:0];
            osd_pkg::CSR_TEXT_FIRST:   text_first_ff   <= csr_data[osd_pkg::TEXT_W-1:0];
            osd_pkg::CSR_TEXT_SECOND:  text_second_ff  <= csr_data[osd_pkg::TEXT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic ended;
      geom_in        = '0;
      geom_in.scale  = glyph_scale_ff;
      geom_in.top[0] = CW'(origin_y_ff);
      geom_in.top[1] = CW'(origin_y_ff) + CW'(line_spacing_ff);
      for (int j = 0; j < osd_pkg::NUM_MULT; j++) begin
         geom_in.mult[j] = MW'(j + 1) * MW'(glyph_scale_ff);
      end
      for (int i = 0; i < osd_pkg::MAX_CHARS; i++) begin
         geom_in.cx[i] = CW'(origin_x_ff) + CW'(i * osd_pkg::GLYPH_PITCH) * CW'(glyph_scale_ff);
         geom_in.code[0][i] = text_first_ff[i*osd_pkg::CODE_W +: osd_pkg::CODE_W];
         geom_in.code[1][i] = text_second_ff[i*osd_pkg::CODE_W +: osd_pkg::CODE_W];
      end
      // A character is drawn when no end code stands at or before it and its code is not the unknown code.
      for (int l = 0; l < osd_pkg::NUM_LINES; l++) begin
         for (int i = 0; i < osd_pkg::MAX_CHARS; i++) begin
            ended = 1'b0;
            for (int j = 0; j <= i; j++) begin
               if (geom_in.code[l][j] == osd_pkg::CODE_END) begin
                  ended = 1'b1;
               end
            end
            geom_in.drawn[l][i] = !ended && (geom_in.code[l][i] != osd_pkg::CODE_UNKNOWN);
         end
      end
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

// ===== src/osd_geom.sv =====
// Front half of the overlay pipeline: input register, cell offsets, and dot indexes by compare.
// Depends on osd_pkg and on the geometry from osd_cfg.
`timescale 1ns / 1ps

module osd_geom (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  osd_pkg::pix_type     in_pix,
   input  osd_pkg::geom_type    geom,
   output logic                 out_valid,
   input  logic                 out_ready,
   output osd_pkg::digit_type   out_digit
);

   localparam int DW = osd_pkg::DIFF_W;
   localparam int GW = osd_pkg::DIGIT_W;

   logic valid0_ff, valid1_ff, valid2_ff;
   logic ready0, ready1, ready2;

   osd_pkg::pix_type   pix_ff;
   osd_pkg::diff_type  diff_ff;
   osd_pkg::diff_type  diff_in;
   osd_pkg::digit_type digit_ff;
   osd_pkg::digit_type digit_in;

   assign ready2   = !valid2_ff || out_ready;
   assign ready1   = !valid1_ff || ready2;
   assign ready0   = !valid0_ff || ready1;
   assign in_ready = ready0 && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready0) valid0_ff <= in_valid;
         if (ready1) valid1_ff <= valid0_ff;
         if (ready2) valid2_ff <= valid1_ff;
      end
   end

   // Offsets of the pixel from every character cell and from both line tops.
   always_comb begin
      diff_in = '0;
      for (int i = 0; i < osd_pkg::MAX_CHARS; i++) begin
         diff_in.dx[i] = DW'(pix_ff.col) - DW'(geom.cx[i]);
      end
      for (int l = 0; l < osd_pkg::NUM_LINES; l++) begin
         diff_in.dy[l] = DW'(pix_ff.row) - DW'(geom.top[l]);
      end
      diff_in.in_frame = (pix_ff.col < osd_pkg::MAX_COORD) && (pix_ff.row < osd_pkg::MAX_COORD);
      diff_in.luma     = pix_ff.luma;
   end

   // The dot index is the count of scale multiples that the offset reaches.
   always_comb begin
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] sx;
      logic signed [DW-1:0] m [osd_pkg::NUM_MULT];
      logic [GW-1:0]        cnt;
      digit_in = '0;
      sx = $signed(DW'(geom.scale));
      for (int j = 0; j < osd_pkg::NUM_MULT; j++) begin
         m[j] = $signed(DW'(geom.mult[j]));
      end
      for (int i = 0; i < osd_pkg::MAX_CHARS; i++) begin
         d = $signed(diff_ff.dx[i]);
         digit_in.col_box[i]   = (d >= -sx) && (d < m[5]);
         digit_in.col_glyph[i] = (d >= 0) && (d < m[4]);
         cnt = '0;
         for (int j = 0; j < 4; j++) begin
            if (d >= m[j]) cnt = cnt + GW'(1);
         end
         digit_in.dc[i] = cnt;
      end
      for (int l = 0; l < osd_pkg::NUM_LINES; l++) begin
         d = $signed(diff_ff.dy[l]);
         digit_in.row_box[l]   = (d >= -sx) && (d < m[7]);
         digit_in.row_glyph[l] = (d >= 0) && (d < m[6]);
         cnt = '0;
         for (int j = 0; j < 6; j++) begin
            if (d >= m[j]) cnt = cnt + GW'(1);
         end
         digit_in.dr[l] = cnt;
      end
      digit_in.in_frame = diff_ff.in_frame;
      digit_in.luma     = diff_ff.luma;
   end

   always_ff @(posedge clock) begin
      if (ready0) pix_ff   <= in_pix;
      if (ready1) diff_ff  <= diff_in;
      if (ready2) digit_ff <= digit_in;
   end

   assign out_valid = valid2_ff;
   assign out_digit = digit_ff;

endmodule

// ===== src/osd_cover.sv =====
// Back half of the overlay pipeline: font lookup per character, last-character-wins
// resolution per line, line priority and the output register. Depends on osd_pkg.
`timescale 1ns / 1ps

module osd_cover (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  osd_pkg::digit_type         in_digit,
   input  osd_pkg::geom_type          geom,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [osd_pkg::LUMA_W-1:0] out_luma
);

   localparam int GW = osd_pkg::DIGIT_W;

   logic valid3_ff, valid4_ff;
   logic ready3, ready4;

   osd_pkg::cover_type          cover_ff;
   osd_pkg::cover_type          cover_in;
   logic [osd_pkg::LUMA_W-1:0]  luma_ff;
   logic [osd_pkg::LUMA_W-1:0]  luma_in;

   assign ready4   = !valid4_ff || out_ready;
   assign ready3   = !valid3_ff || ready4;
   assign in_ready = ready3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready3) valid3_ff <= in_valid;
         if (ready4) valid4_ff <= valid3_ff;
      end
   end

   always_comb begin
      logic [osd_pkg::FONT_W-1:0] bits;
      logic [GW-1:0]              sel;
      cover_in = '0;
      for (int l = 0; l < osd_pkg::NUM_LINES; l++) begin
         for (int i = 0; i < osd_pkg::MAX_CHARS; i++) begin
            bits = osd_pkg::font_row(geom.code[l][i], in_digit.dr[l]);
            sel  = GW'(osd_pkg::FONT_W - 1) - in_digit.dc[i];
            cover_in.box[l][i] = geom.drawn[l][i] && in_digit.col_box[i] &&
                                 in_digit.row_box[l];
            cover_in.dot[l][i] = geom.drawn[l][i] && in_digit.col_glyph[i] &&
                                 in_digit.row_glyph[l] && bits[sel];
         end
      end
      cover_in.in_frame = in_digit.in_frame;
      cover_in.luma     = in_digit.luma;
   end

   // Within a line the rightmost covering character decides, so a dot only counts
   // when no box of a later character covers the pixel as well.
   always_comb begin
      logic [osd_pkg::NUM_LINES-1:0] any_box;
      logic [osd_pkg::NUM_LINES-1:0] any_dot;
      logic [osd_pkg::MAX_CHARS-1:0] later;
      any_box = '0;
      any_dot = '0;
      for (int l = 0; l < osd_pkg::NUM_LINES; l++) begin
         any_box[l] = |cover_ff.box[l];
         for (int i = 0; i < osd_pkg::MAX_CHARS; i++) begin
            later = cover_ff.box[l] >> (i + 1);
            if (cover_ff.dot[l][i] && (later == '0)) any_dot[l] = 1'b1;
         end
      end
      priority if (!cover_ff.in_frame) begin
         luma_in = cover_ff.luma;
      end else if (any_box[1]) begin
         luma_in = any_dot[1] ? osd_pkg::LUMA_DOT : osd_pkg::LUMA_BOX;
      end else if (any_box[0]) begin
         luma_in = any_dot[0] ? osd_pkg::LUMA_DOT : osd_pkg::LUMA_BOX;
      end else begin
         luma_in = cover_ff.luma;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) cover_ff <= cover_in;
      if (ready4) luma_ff  <= luma_in;
   end

   assign out_valid = valid4_ff;
   assign out_luma  = luma_ff;

endmodule

// ===== src/osd_text_overlay.sv =====
// Text overlay top level, from an accepted pixel word to its luma word.
// Throughput is one word per clock, set by the five register stages (input, offsets, dot
// indexes, font cover, output) that each hand over a word every cycle unless stalled.
// Reset is synchronous: it clears the stage valid bits and reloads the registers with their
// defaults; the derived geometry is registered and follows a register write in the cycle after it.
`timescale 1ns / 1ps

module osd_text_overlay (
   input  logic       clock,
   input  logic       reset,
   osd_req_if.sink    req_bus,
   osd_rsp_if.source  rsp_bus,
   osd_csr_if.sink    csr_bus
);

   // Geometry shared by both pipeline halves. The user must only change it while the pipeline is
   // empty, so every stage may look at the same copy; the block itself does not enforce it.
   osd_pkg::geom_type  geom;

   osd_pkg::pix_type   req_pix;
   osd_pkg::digit_type mid_digit;
   logic               mid_valid;
   logic               mid_ready;

   osd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .geom      (geom)
   );

   assign req_pix.col  = req_bus.pixel_col;
   assign req_pix.row  = req_bus.pixel_row;
   assign req_pix.luma = req_bus.luma_in;

   // First three stages: capture the word, take the offsets from every character
   // cell and line top, then turn them into box flags and font dot indexes.
   osd_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_pix    (req_pix),
      .geom      (geom),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_digit (mid_digit)
   );

   // Last two stages: read the font for each character of each line, let the
   // rightmost character and then the second line win, and register the result.
   // The output register lets a new word enter while a finished one waits.
   osd_cover u_cover (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_digit  (mid_digit),
      .geom      (geom),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_luma  (rsp_bus.luma_out)
   );

endmodule

// ===== src/osd_text_overlay_chk.sv =====
// Port-level checker of the text overlay and its bind to the top level.
// Depends on the assertion macros in osd_text_overlay_defines.svh.
`timescale 1ns / 1ps
`include "osd_text_overlay_defines.svh"

module osd_text_overlay_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [osd_pkg::LUMA_W-1:0] luma_out
);

   `OSD_ASSERT_NOW(a_no_stall_when_drained, rsp_ready, req_ready, "input stalled although output is taken")
   `OSD_ASSERT_NEXT(a_latency, (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid, "word did not arrive after four cycles")
   `OSD_ASSERT_NEXT(a_hold_stalled, rsp_valid && !rsp_ready, rsp_valid && $stable(luma_out), "stalled output word changed")
   `OSD_ASSERT_NOW(a_reset_empties, $past(reset), !rsp_valid, "output valid straight after reset")

endmodule

bind osd_text_overlay osd_text_overlay_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .luma_out  (rsp_bus.luma_out)
);
